>>> rtl/load_based_core_hotplug_governor_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the core hotplug governor
// Clocked implication checks used by the top-level governor file of the block.
// ---------------------------------------------------------------------------
`ifndef LOAD_BASED_CORE_HOTPLUG_GOVERNOR_ASSERT_SVH
`define LOAD_BASED_CORE_HOTPLUG_GOVERNOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LBCHG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("governor check failed");

// Next-cycle implication, disabled during reset.
`define LBCHG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("governor check failed");

`endif

>>> rtl/lbchg_pkg.sv
// ---------------------------------------------------------------------------
// lbchg_pkg
// Types, codes and constants shared by the core hotplug governor.
// ---------------------------------------------------------------------------
package lbchg_pkg;

    localparam int POSSIBLE_CORES = 4;
    localparam int TIME_BITS      = 64;

    localparam logic [7:0]  SPIKE_LOAD     = 8'(90 << 1);
    localparam logic [31:0] SCREEN_OFF_CAP = 32'd1036800;
    localparam int          US_PER_MS      = 1000;
    localparam logic [23:0] SECOND_US      = 24'(1000 * US_PER_MS);
    localparam logic [6:0]  FULL_THRESHOLD = 7'd100;
    localparam logic [2:0]  ONE_CORE       = 3'd1;
    localparam logic [2:0]  TWO_CORES      = 3'd2;
    localparam logic [2:0]  ALL_CORES      = 3'(POSSIBLE_CORES);

    // Configuration register indexes.
    localparam logic [2:0] CFG_UP_LOAD_PCT        = 3'd0;
    localparam logic [2:0] CFG_UP_COUNT_NEEDED    = 3'd1;
    localparam logic [2:0] CFG_COUNT_CEILING      = 3'd2;
    localparam logic [2:0] CFG_UNPLUG_FREQ_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_MIN_ONLINE_SECONDS = 3'd4;

    typedef enum logic [1:0] {
        MODE_SAMPLE     = 2'd0,
        MODE_SCREEN_OFF = 2'd1,
        MODE_SCREEN_ON  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_UP      = 3'd1,
        ACT_DOWN    = 3'd2,
        ACT_SUSPEND = 3'd3,
        ACT_RESUME  = 3'd4
    } action_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  online_cores;
        logic [7:0]  load_sum;
        logic        policy_valid;
        logic [31:0] policy_min_freq;
        logic [31:0] policy_max_freq;
        logic [31:0] core2_freq;
        logic [31:0] core3_freq;
        logic [63:0] now_us;
    } in_item_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] freq_ceiling;
        logic [5:0]  load_count;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  up_load_pct;
        logic [5:0]  up_count_needed;
        logic [5:0]  count_ceiling;
        logic [31:0] unplug_freq_limit;
        logic [3:0]  min_online_seconds;
    } cfg_t;

    // Minimum on-time in microseconds; below two seconds means one.
    function automatic logic [23:0] on_time_us(input logic [3:0] secs);
        logic [23:0] us;
        us = (secs > 4'd1) ? 24'(secs) * SECOND_US : SECOND_US;
        return us;
    endfunction

endpackage

>>> rtl/lbchg_ifs.sv
// ---------------------------------------------------------------------------
// lbchg channel interfaces
// Valid/ready channels carrying sample items in and decision items out.
// ---------------------------------------------------------------------------
interface lbchg_in_if;
    logic                 valid;
    logic                 ready;
    lbchg_pkg::in_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface lbchg_out_if;
    logic                 valid;
    logic                 ready;
    lbchg_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/lbchg_core.sv
// ---------------------------------------------------------------------------
// lbchg_core
// Governor state and the single-pass decision for one item.
// ---------------------------------------------------------------------------
module lbchg_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbchg_pkg::cfg_t      cfg,
    input  logic                 fire,
    input  lbchg_pkg::in_item_t  item,
    output lbchg_pkg::out_item_t result
);

    localparam int TB = lbchg_pkg::TIME_BITS;

    logic [5:0]    load_counter_reg, load_counter_next;
    logic [TB-1:0] last_up_time_reg, last_up_time_next;
    logic [31:0]   saved_max_freq_reg, saved_max_freq_next;
    logic          suspended_reg, suspended_next;

    logic [TB-1:0] now_t;
    logic          skip;
    logic          busy;
    logic [5:0]    cnt_inc;
    logic [5:0]    cnt_dec;
    logic [32:0]   freq_sum;
    logic          freq_holds;
    logic [TB-1:0] base_time;
    logic [TB-1:0] deadline;
    logic [23:0]   extra_us;

    assign now_t     = item.now_us[TB-1:0];
    assign skip      = (item.online_cores == lbchg_pkg::ONE_CORE) || suspended_reg
                     || (cfg.up_load_pct == lbchg_pkg::FULL_THRESHOLD
                         && item.online_cores == lbchg_pkg::TWO_CORES)
                     || (cfg.up_load_pct == 7'd0
                         && item.online_cores == lbchg_pkg::ALL_CORES);
    assign busy      = item.load_sum >= {cfg.up_load_pct, 1'b0};
    assign cnt_inc   = (load_counter_reg < cfg.count_ceiling) ? load_counter_reg + 6'd1
                                                              : load_counter_reg;
    assign cnt_dec   = (load_counter_reg != 6'd0) ? load_counter_reg - 6'd1 : load_counter_reg;

    // Mean of the upper-core clocks, summed one bit wider so it never wraps.
    assign freq_sum   = {1'b0, item.core2_freq} + {1'b0, item.core3_freq};
    assign freq_holds = !(item.policy_valid && item.policy_min_freq >= cfg.unplug_freq_limit)
                        && (freq_sum[32:1] >= cfg.unplug_freq_limit);
    assign base_time  = freq_holds ? now_t : last_up_time_reg;
    assign extra_us   = lbchg_pkg::on_time_us(cfg.min_online_seconds);
    assign deadline   = base_time + {{(TB-24){1'b0}}, extra_us};

    always_comb
    begin
        load_counter_next   = load_counter_reg;
        last_up_time_next   = last_up_time_reg;
        saved_max_freq_next = saved_max_freq_reg;
        suspended_next      = suspended_reg;
        result.action       = lbchg_pkg::ACT_NONE;
        result.freq_ceiling = 32'd0;
        unique case (item.mode)
            lbchg_pkg::MODE_SCREEN_OFF:
            begin
                saved_max_freq_next = item.policy_valid ? item.policy_max_freq : '1;
                load_counter_next   = 6'd0;
                suspended_next      = 1'b1;
                result.action       = lbchg_pkg::ACT_SUSPEND;
                result.freq_ceiling = lbchg_pkg::SCREEN_OFF_CAP;
            end
            lbchg_pkg::MODE_SCREEN_ON:
            begin
                result.freq_ceiling = (saved_max_freq_reg != 32'd0) ? saved_max_freq_reg : '1;
                suspended_next      = 1'b0;
                result.action       = lbchg_pkg::ACT_RESUME;
            end
            lbchg_pkg::MODE_SAMPLE:
            begin
                if (!skip)
                begin
                    if (busy)
                    begin
                        load_counter_next = cnt_inc;
                        if (item.online_cores <= lbchg_pkg::TWO_CORES
                            && ((item.load_sum >= lbchg_pkg::SPIKE_LOAD && cnt_inc >= 6'd2)
                                || cnt_inc >= cfg.up_count_needed))
                        begin
                            result.action     = lbchg_pkg::ACT_UP;
                            last_up_time_next = now_t;
                        end
                    end
                    else
                    begin
                        load_counter_next = cnt_dec;
                        if (item.online_cores > lbchg_pkg::TWO_CORES
                            && cnt_dec < cfg.up_count_needed)
                        begin
                            last_up_time_next = base_time;
                            if (now_t >= deadline)
                            begin
                                result.action     = lbchg_pkg::ACT_DOWN;
                                load_counter_next = 6'd0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                result.action = lbchg_pkg::ACT_NONE;
            end
        endcase
        result.load_count = load_counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_counter_reg   <= 6'd0;
            last_up_time_reg   <= '0;
            saved_max_freq_reg <= 32'd0;
            suspended_reg      <= 1'b0;
        end
        else if (fire)
        begin
            load_counter_reg   <= load_counter_next;
            last_up_time_reg   <= last_up_time_next;
            saved_max_freq_reg <= saved_max_freq_next;
            suspended_reg      <= suspended_next;
        end
    end

endmodule

>>> rtl/load_based_core_hotplug_governor.sv
// ---------------------------------------------------------------------------
// load_based_core_hotplug_governor
// Power-up/power-down decisions for the upper two cores of a 4-core cluster.
// ---------------------------------------------------------------------------
// Each item on samples is a load sample, a screen-off or a screen-on event;
// each yields exactly one decision item on decisions, in order. The block
// sustains one item per clock while decisions takes each decision as it is
// offered: an item is captured in the input register, decided in one pass of
// logic against the governor state, and loaded into the result register,
// from which it is offered on decisions until the sink takes it.
// That single decision pass, ending in one 64-bit time add and compare, sets
// the figure. The input register keeps accepting while a finished decision
// waits to be taken, and stalls only when both are full.
// Configuration is a plain write port; write it only while the block is idle.
// ---------------------------------------------------------------------------
`include "load_based_core_hotplug_governor_assert.svh"

module load_based_core_hotplug_governor (
    input  logic        clk,
    input  logic        rst_n,
    lbchg_in_if.sink    samples,
    lbchg_out_if.source decisions,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers, reset to the power-on policy.
    lbchg_pkg::cfg_t cfg_reg;

    // Input register: holds one accepted item until it is decided.
    logic                 s1_valid_reg;
    lbchg_pkg::in_item_t  s1_item_reg;

    // Result register: holds one decision until the sink takes it.
    logic                 out_valid_reg;
    lbchg_pkg::out_item_t out_item_reg;

    logic                 advance;
    lbchg_pkg::out_item_t decided;

    // Short terms for the checks at the end.
    logic                 screen_off_adv;
    logic                 out_suspend;
    logic                 out_down;
    logic                 out_plain;
    logic                 out_count_zero;
    logic                 out_cap_zero;

    // Advance the decided item whenever the result slot is free or draining.
    assign advance       = s1_valid_reg && (!out_valid_reg || decisions.ready);
    assign samples.ready = !s1_valid_reg || advance;

    assign decisions.valid = out_valid_reg;
    assign decisions.item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_load_pct        <= 7'd80;
            cfg_reg.up_count_needed    <= 6'd10;
            cfg_reg.count_ceiling      <= 6'd20;
            cfg_reg.unplug_freq_limit  <= 32'd1497600;
            cfg_reg.min_online_seconds <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lbchg_pkg::CFG_UP_LOAD_PCT:
                    cfg_reg.up_load_pct        <= cfg_data[6:0];
                lbchg_pkg::CFG_UP_COUNT_NEEDED:
                    cfg_reg.up_count_needed    <= cfg_data[5:0];
                lbchg_pkg::CFG_COUNT_CEILING:
                    cfg_reg.count_ceiling      <= cfg_data[5:0];
                lbchg_pkg::CFG_UNPLUG_FREQ_LIMIT:
                    cfg_reg.unplug_freq_limit  <= cfg_data;
                lbchg_pkg::CFG_MIN_ONLINE_SECONDS:
                    cfg_reg.min_online_seconds <= cfg_data[3:0];
                default:
                    cfg_reg <= cfg_reg;     // drop writes beyond the list
            endcase
        end
    end

    // Input stage control: fill on accept, empty when the item is decided.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_item_reg <= samples.item;
        end
    end

    // Decision logic and governor state; the state moves only on advance.
    lbchg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fire   (advance),
        .item   (s1_item_reg),
        .result (decided)
    );

    // Result stage control: load on advance, clear once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (decisions.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= decided;
        end
    end

    assign screen_off_adv = advance && s1_item_reg.mode == lbchg_pkg::MODE_SCREEN_OFF;
    assign out_suspend    = out_valid_reg && out_item_reg.action == lbchg_pkg::ACT_SUSPEND;
    assign out_down       = out_valid_reg && out_item_reg.action == lbchg_pkg::ACT_DOWN;
    assign out_plain      = out_valid_reg && out_item_reg.action != lbchg_pkg::ACT_SUSPEND
                            && out_item_reg.action != lbchg_pkg::ACT_RESUME;
    assign out_count_zero = out_item_reg.load_count == 6'd0;
    assign out_cap_zero   = out_item_reg.freq_ceiling == 32'd0;

    // A screen-off item must come out as a suspend decision.
    `LBCHG_ASSERT_NEXT(a_screen_off_suspends, clk, rst_n, screen_off_adv, out_suspend)
    // Taking cores down always restarts the load counter.
    `LBCHG_ASSERT_IMP(a_down_clears_count, clk, rst_n, out_down, out_count_zero)
    // Only suspend and resume carry a frequency ceiling.
    `LBCHG_ASSERT_IMP(a_ceiling_only_on_screen, clk, rst_n, out_plain, out_cap_zero)

endmodule
